// File: hw/rtl/scsu_ex_pkg.sv
// shared types, constants and window helpers for the scsu expander
`timescale 1ns / 1ps

package scsu_ex_pkg;

	localparam logic [19:0] MAX_UNITS = 20'd65535;
	localparam logic [17:0] COUNT_MAX = 18'h3FFFF;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// result status codes
	localparam logic [1:0] ST_UNIT     = 2'd0;
	localparam logic [1:0] ST_LIMIT    = 2'd1;
	localparam logic [1:0] ST_RESERVED = 2'd2;
	localparam logic [1:0] ST_ENDED    = 2'd3;

	typedef logic [20:0] base_t;

	// partly read tag
	typedef enum logic [7:0] {
		PK_NONE = 8'b0000_0001,
		PK_ULOW = 8'b0000_0010,
		PK_QHI  = 8'b0000_0100,
		PK_QLO  = 8'b0000_1000,
		PK_DEF  = 8'b0001_0000,
		PK_XHI  = 8'b0010_0000,
		PK_XLO  = 8'b0100_0000,
		PK_SQ   = 8'b1000_0000
	} pend_t;

	localparam base_t DYN_DEFAULT [0:7] = '{
		21'h00080, 21'h000C0, 21'h00400, 21'h00600,
		21'h00900, 21'h03040, 21'h030A0, 21'h0FF00
	};

	localparam base_t STATIC_WIN [0:7] = '{
		21'h00000, 21'h00080, 21'h00100, 21'h00300,
		21'h02000, 21'h02080, 21'h02100, 21'h03000
	};

	localparam base_t FIXED_OFFSETS [0:6] = '{
		21'h000C0, 21'h00250, 21'h00370, 21'h00530,
		21'h03040, 21'h030A0, 21'h0FF60
	};

	// one decoded byte: up to two units, then an optional done result
	typedef struct packed {
		logic [15:0] unit0;
		logic [15:0] unit1;
		logic [1:0]  n_units;
		logic        has_done;
		logic [1:0]  done_status;
		logic [17:0] done_count;
	} run_t;

	function automatic base_t offset_base(input logic [7:0] x);
		logic [2:0] idx;
		base_t      res;
		idx = 3'(x - 8'hF9);
		if (x >= 8'hF9) begin
			res = FIXED_OFFSETS[idx];
		end else if (x >= 8'h01 && x <= 8'h67) begin
			res = {6'b0, x, 7'b0};
		end else if (x >= 8'h68 && x <= 8'hA7) begin
			res = {6'b0, x, 7'b0} + 21'h0AC00;
		end else begin
			res = '0;
		end
		return res;
	endfunction

endpackage

// File: hw/rtl/scsu_unicode_expander_top.sv
// scsu expander top: decoder front end, run queue and result sequencer
// a byte's first word goes into the run queue, then into the output register, before it shows on out_valid
// throughput: one byte per cycle while each byte gives at most one word and out_stall is low; a byte
// that gives several words holds the output register while they go out one by one through the single result port
// a four-entry run queue absorbs bursts; in_stall is high only while it is full
// reset: async, windows go to their default bases, no string is open, queue and output empty
`timescale 1ns / 1ps

module scsu_unicode_expander_top import scsu_ex_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	input  logic [15:0] unit_limit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] code_unit,
	output logic [1:0]  status,
	output logic [17:0] byte_count,
	output logic        last_of_run
);

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	run_t push_run;
	run_t q_head;

	scsu_ex_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.unit_limit (unit_limit),
		.q_full     (q_full),
		.push       (q_push),
		.push_run   (push_run)
	);

	scsu_ex_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_run (push_run),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	scsu_ex_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_unit   (code_unit),
		.status      (status),
		.byte_count  (byte_count),
		.last_of_run (last_of_run)
	);

	// a done word always closes the run of its byte
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_UNIT |-> last_of_run)
		else $error("done word not marked last of run");

	// done words carry no code unit
	a_done_no_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_UNIT |-> code_unit == 16'h0000)
		else $error("done word carries a code unit");

	// unit words carry no byte count
	a_unit_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNIT |-> byte_count == 18'h00000)
		else $error("unit word carries a byte count");

endmodule

// File: hw/rtl/scsu_ex_front.sv
// front end: takes source bytes, runs the tag decoder and window state, builds runs
`timescale 1ns / 1ps

module scsu_ex_front import scsu_ex_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	input  logic [15:0] unit_limit,
	input  logic        q_full,
	output logic        push,
	output run_t        push_run
);

	localparam logic [7:0] BC_SQ0    = 8'h01;
	localparam logic [7:0] BC_SQ7    = 8'h08;
	localparam logic [7:0] BC_TAB    = 8'h09;
	localparam logic [7:0] BC_LF     = 8'h0A;
	localparam logic [7:0] BC_SDX    = 8'h0B;
	localparam logic [7:0] BC_CR     = 8'h0D;
	localparam logic [7:0] BC_SQU    = 8'h0E;
	localparam logic [7:0] BC_SCU    = 8'h0F;
	localparam logic [7:0] BC_SC0    = 8'h10;
	localparam logic [7:0] BC_SC7    = 8'h17;
	localparam logic [7:0] BC_SD0    = 8'h18;
	localparam logic [7:0] BC_SD7    = 8'h1F;
	localparam logic [7:0] BC_SPACE  = 8'h20;
	localparam logic [7:0] BC_UCHI   = 8'hDF;
	localparam logic [7:0] BC_UC0    = 8'hE0;
	localparam logic [7:0] BC_UC7    = 8'hE7;
	localparam logic [7:0] BC_UD0    = 8'hE8;
	localparam logic [7:0] BC_UD7    = 8'hEF;
	localparam logic [7:0] BC_UQU    = 8'hF0;
	localparam logic [7:0] BC_UDX    = 8'hF1;
	localparam logic [7:0] BC_UHILO  = 8'hF3;

	base_t       wb_q [0:7];
	base_t       ab_q;
	logic        um_q;
	pend_t       pk_q;
	logic [7:0]  ph_q;
	logic [2:0]  pw_q;
	logic [16:0] ue_q;
	logic [15:0] lim_q;
	logic [17:0] bc_q;
	logic        fin_q;

	base_t       wb_n [0:7];
	base_t       ab_n;
	logic        um_n;
	pend_t       pk_n;
	logic [7:0]  ph_n;
	logic [2:0]  pw_n;
	logic [16:0] ue_n;
	logic [15:0] lim_n;
	logic [17:0] bc_n;
	logic        fin_n;

	logic        accept;
	logic        go;
	logic        ok;
	pend_t       k;
	logic [2:0]  rd_sel;
	base_t       rd_base;
	logic        emit_raw;
	logic [15:0] raw_unit;
	logic        emit_cp;
	base_t       cp_base;
	base_t       cp;
	logic [19:0] cp_off;
	logic [1:0]  n_units;
	logic [19:0] eff_limit;
	run_t        rec;
	logic        do_push;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && do_push;
	assign push_run = rec;

	always_comb begin
		wb_n     = wb_q;
		ab_n     = ab_q;
		um_n     = um_q;
		pk_n     = pk_q;
		ph_n     = ph_q;
		pw_n     = pw_q;
		ue_n     = ue_q;
		lim_n    = lim_q;
		bc_n     = bc_q;
		fin_n    = fin_q;
		go       = 1'b0;
		ok       = 1'b1;
		k        = PK_NONE;
		emit_raw = 1'b0;
		raw_unit = '0;
		emit_cp  = 1'b0;
		cp_base  = '0;
		cp       = '0;
		cp_off   = '0;
		n_units  = 2'd0;
		rec      = '0;
		do_push  = 1'b0;

		if (first_byte) begin
			wb_n  = DYN_DEFAULT;
			ab_n  = 21'h00080;
			um_n  = 1'b0;
			pk_n  = PK_NONE;
			ph_n  = '0;
			pw_n  = '0;
			ue_n  = '0;
			lim_n = unit_limit;
			bc_n  = '0;
			fin_n = 1'b0;
		end

		eff_limit = ({4'b0, lim_n} < MAX_UNITS) ? {4'b0, lim_n} : MAX_UNITS;

		if (first_byte && eff_limit == '0) begin
			// zero limit: byte is not consumed
			rec.has_done    = 1'b1;
			rec.done_status = ST_LIMIT;
			rec.done_count  = '0;
			fin_n           = 1'b1;
			do_push         = 1'b1;
		end else if (first_byte || !fin_q) begin
			go = 1'b1;
		end

		rd_sel  = (pk_n == PK_SQ) ? pw_n : data_byte[2:0];
		rd_base = wb_n[rd_sel];

		if (go) begin
			if (bc_n != COUNT_MAX) begin
				bc_n = bc_n + 18'd1;
			end
			k    = pk_n;
			pk_n = PK_NONE;
			unique case (k)
				PK_ULOW, PK_QLO: begin
					emit_raw = 1'b1;
					raw_unit = {ph_n, data_byte};
				end
				PK_QHI: begin
					ph_n = data_byte;
					pk_n = PK_QLO;
				end
				PK_DEF: begin
					um_n       = 1'b0;
					ab_n       = offset_base(data_byte);
					wb_n[pw_n] = ab_n;
				end
				PK_XHI: begin
					ph_n = data_byte;
					pk_n = PK_XLO;
				end
				PK_XLO: begin
					um_n            = 1'b0;
					ab_n            = 21'h10000 + {1'b0, ph_n[4:0], data_byte, 7'b0};
					wb_n[ph_n[7:5]] = ab_n;
				end
				PK_SQ: begin
					emit_cp = 1'b1;
					cp_base = data_byte[7] ? rd_base : STATIC_WIN[pw_n];
				end
				PK_NONE: begin
					if (um_n) begin
						priority if (data_byte <= BC_UCHI || data_byte >= BC_UHILO) begin
							ph_n = data_byte;
							pk_n = PK_ULOW;
						end else if (data_byte == BC_UQU) begin
							pk_n = PK_QHI;
						end else if (data_byte >= BC_UC0 && data_byte <= BC_UC7) begin
							ab_n = rd_base;
							um_n = 1'b0;
						end else if (data_byte >= BC_UD0 && data_byte <= BC_UD7) begin
							pw_n = data_byte[2:0];
							pk_n = PK_DEF;
						end else if (data_byte == BC_UDX) begin
							pk_n = PK_XHI;
						end else begin
							ok = 1'b0;
						end
					end else begin
						priority if (data_byte == 8'h00 || data_byte == BC_TAB ||
								data_byte == BC_LF || data_byte == BC_CR ||
								(data_byte >= BC_SPACE && !data_byte[7])) begin
							emit_raw = 1'b1;
							raw_unit = {8'h00, data_byte};
						end else if (data_byte[7]) begin
							emit_cp = 1'b1;
							cp_base = ab_n;
						end else if (data_byte == BC_SQU) begin
							pk_n = PK_QHI;
						end else if (data_byte == BC_SCU) begin
							um_n = 1'b1;
						end else if (data_byte >= BC_SQ0 && data_byte <= BC_SQ7) begin
							pw_n = 3'(data_byte - BC_SQ0);
							pk_n = PK_SQ;
						end else if (data_byte >= BC_SC0 && data_byte <= BC_SC7) begin
							ab_n = rd_base;
						end else if (data_byte >= BC_SD0 && data_byte <= BC_SD7) begin
							pw_n = data_byte[2:0];
							pk_n = PK_DEF;
						end else if (data_byte == BC_SDX) begin
							pk_n = PK_XHI;
						end else begin
							ok = 1'b0;
						end
					end
				end
				default: begin
					ok = 1'b1;
				end
			endcase

			// code point to one unit or a surrogate pair
			cp     = cp_base + {14'b0, data_byte[6:0]};
			cp_off = 20'(cp - 21'h10000);
			if (emit_raw) begin
				rec.unit0 = raw_unit;
				n_units   = 2'd1;
			end else if (emit_cp) begin
				if (cp <= 21'h0FFFF) begin
					rec.unit0 = cp[15:0];
					n_units   = 2'd1;
				end else if (cp <= 21'h10FFFF) begin
					rec.unit0 = 16'hD800 + {6'b0, cp_off[19:10]};
					rec.unit1 = 16'hDC00 + {6'b0, cp_off[9:0]};
					n_units   = 2'd2;
				end
			end
			rec.n_units = n_units;
			ue_n        = ue_n + {15'b0, n_units};

			if (!ok) begin
				rec.has_done    = 1'b1;
				rec.done_status = ST_RESERVED;
				fin_n           = 1'b1;
			end else if (pk_n == PK_NONE && {3'b0, ue_n} >= eff_limit) begin
				rec.has_done    = 1'b1;
				rec.done_status = ST_LIMIT;
				fin_n           = 1'b1;
			end else if (last_byte) begin
				rec.has_done    = 1'b1;
				rec.done_status = ST_ENDED;
				fin_n           = 1'b1;
			end
			rec.done_count = bc_n;
			do_push        = rec.has_done || (n_units != 2'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q  <= DYN_DEFAULT;
			ab_q  <= 21'h00080;
			um_q  <= 1'b0;
			pk_q  <= PK_NONE;
			ph_q  <= '0;
			pw_q  <= '0;
			ue_q  <= '0;
			lim_q <= '0;
			bc_q  <= '0;
			fin_q <= 1'b1;
		end else if (accept) begin
			wb_q  <= wb_n;
			ab_q  <= ab_n;
			um_q  <= um_n;
			pk_q  <= pk_n;
			ph_q  <= ph_n;
			pw_q  <= pw_n;
			ue_q  <= ue_n;
			lim_q <= lim_n;
			bc_q  <= bc_n;
			fin_q <= fin_n;
		end
	end

endmodule

// File: hw/rtl/scsu_ex_queue.sv
// short run queue between the decoder front end and the result sequencer
`timescale 1ns / 1ps

module scsu_ex_queue import scsu_ex_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  run_t push_run,
	output logic full,
	input  logic pop,
	output logic empty,
	output run_t head
);

	run_t              mem_q [0:QUEUE_DEPTH-1];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/scsu_ex_back.sv
// back end: walks each queued run and presents its words through an output register
`timescale 1ns / 1ps

module scsu_ex_back import scsu_ex_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  run_t        q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] code_unit,
	output logic [1:0]  status,
	output logic [17:0] byte_count,
	output logic        last_of_run
);

	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic [15:0] code_q;
	logic [1:0]  status_q;
	logic [17:0] count_q;
	logic        last_q;

	logic        can_load;
	logic        load;
	logic [1:0]  total;
	logic        is_last;
	logic [15:0] nxt_code;
	logic [1:0]  nxt_status;
	logic [17:0] nxt_count;

	assign can_load = !out_valid_q || !out_stall;
	assign load     = can_load && !q_empty;
	assign total    = q_head.n_units + {1'b0, q_head.has_done};
	assign is_last  = (idx_q == total - 2'd1);
	assign q_pop    = load && is_last;

	always_comb begin
		if (idx_q < q_head.n_units) begin
			nxt_code   = (idx_q == 2'd0) ? q_head.unit0 : q_head.unit1;
			nxt_status = ST_UNIT;
			nxt_count  = '0;
		end else begin
			nxt_code   = '0;
			nxt_status = q_head.done_status;
			nxt_count  = q_head.done_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= !q_empty;
			if (load) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q   <= nxt_code;
			status_q <= nxt_status;
			count_q  <= nxt_count;
			last_q   <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign code_unit   = code_q;
	assign status      = status_q;
	assign byte_count  = count_q;
	assign last_of_run = last_q;

endmodule

// File: bench/scsu_expander_checker.sv
// tag byte codes for the bench, and a checker that predicts and compares expander words
`timescale 1ns / 1ps

package scsu_tag_pkg;

	// single-byte mode tags
	localparam logic [7:0] SQ0  = 8'h01;
	localparam logic [7:0] SDX  = 8'h0B;
	localparam logic [7:0] SRSV = 8'h0C;
	localparam logic [7:0] SQU  = 8'h0E;
	localparam logic [7:0] SCU  = 8'h0F;
	localparam logic [7:0] SC0  = 8'h10;
	localparam logic [7:0] SD0  = 8'h18;

	// unicode mode tags
	localparam logic [7:0] UC0  = 8'hE0;
	localparam logic [7:0] UD0  = 8'hE8;
	localparam logic [7:0] UQU  = 8'hF0;
	localparam logic [7:0] UDX  = 8'hF1;
	localparam logic [7:0] URSV = 8'hF2;

endpackage

module scsu_expander_checker import scsu_ex_pkg::*, scsu_tag_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	input  logic [15:0] unit_limit,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] code_unit,
	input  logic [1:0]  status,
	input  logic [17:0] byte_count,
	input  logic        last_of_run,
	output int          fail_count,
	output int          words_pending
);

	typedef struct packed {
		logic [15:0] cu;
		logic [1:0]  st;
		logic [17:0] cnt;
		logic        tail;
	} word_t;

	localparam base_t HOME_BASES [8] = '{
		21'h00080, 21'h000C0, 21'h00400, 21'h00600,
		21'h00900, 21'h03040, 21'h030A0, 21'h0FF00
	};
	localparam base_t STATIC_BASES [8] = '{
		21'h00000, 21'h00080, 21'h00100, 21'h00300,
		21'h02000, 21'h02080, 21'h02100, 21'h03000
	};
	localparam base_t FIXED_BASES [7] = '{
		21'h000C0, 21'h00250, 21'h00370, 21'h00530,
		21'h03040, 21'h030A0, 21'h0FF60
	};

	base_t       win_base [8];
	base_t       cur_base;
	logic        uni_mode;
	pend_t       tag;
	logic [7:0]  tag_hi;
	logic [2:0]  tag_win;
	logic [16:0] units_out;
	logic [15:0] lim_q;
	logic [17:0] bytes_in;
	logic        closed;

	word_t words_due [$];
	int    run_len;
	int    miss_cnt = 0;
	int    due_cnt = 0;

	assign fail_count = miss_cnt;
	assign words_pending = due_cnt;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
		miss_cnt++;
	endtask

	function automatic base_t window_offset(input logic [7:0] x);
		if (x >= 8'hF9)
			return FIXED_BASES[x - 8'hF9];
		if (x >= 8'h01 && x <= 8'h67)
			return base_t'(x) << 7;
		if (x >= 8'h68 && x <= 8'hA7)
			return (base_t'(x) << 7) + 21'h0AC00;
		return '0;
	endfunction

	function automatic logic [19:0] unit_cap();
		return (20'(lim_q) < MAX_UNITS) ? 20'(lim_q) : MAX_UNITS;
	endfunction

	task automatic queue_word(input logic [15:0] cu, input logic [1:0] st, input logic [17:0] cnt);
		word_t w;
		w = '{cu: cu, st: st, cnt: cnt, tail: 1'b0};
		words_due.insert(words_due.size(), w);
		run_len++;
	endtask

	task automatic push_unit(input logic [15:0] cu);
		queue_word(cu, ST_UNIT, 18'd0);
		units_out = units_out + 17'd1;
	endtask

	// code points past the bmp go out as a surrogate pair
	task automatic push_point(input int unsigned cp);
		int unsigned v;
		v = cp - 32'h10000;
		if (cp <= 32'hFFFF) begin
			push_unit(16'(cp));
		end else if (cp <= 32'h10FFFF) begin
			push_unit(16'hD800 + 16'(v >> 10));
			push_unit(16'hDC00 + 16'(v & 32'h3FF));
		end
	endtask

	task automatic load_window(input logic [2:0] idx, input base_t b);
		uni_mode = 1'b0;
		cur_base = b;
		win_base[idx] = b;
	endtask

	task automatic open_string(input logic [15:0] lim);
		win_base = HOME_BASES;
		cur_base = 21'h00080;
		uni_mode = 1'b0;
		tag = PK_NONE;
		tag_hi = 8'h00;
		tag_win = 3'd0;
		units_out = '0;
		lim_q = lim;
		bytes_in = '0;
	endtask

	// ok goes low on a reserved tag
	task automatic expand(input logic [7:0] b, output bit ok);
		pend_t k;
		k = tag;
		tag = PK_NONE;
		ok = 1'b1;
		case (k)
			PK_ULOW, PK_QLO: push_unit({tag_hi, b});
			PK_QHI: begin
				tag_hi = b;
				tag = PK_QLO;
			end
			PK_DEF: load_window(tag_win, window_offset(b));
			PK_XHI: begin
				tag_hi = b;
				tag = PK_XLO;
			end
			PK_XLO: load_window(tag_hi[7:5], 21'h10000 + {1'b0, tag_hi[4:0], b, 7'b0});
			PK_SQ: begin
				if (b <= 8'h7F)
					push_point(int'(STATIC_BASES[tag_win]) + b);
				else
					push_point(int'(win_base[tag_win]) + b - 32'h80);
			end
			default: begin
				if (uni_mode) begin
					if (b <= 8'hDF || b >= 8'hF3) begin
						tag_hi = b;
						tag = PK_ULOW;
					end else if (b == UQU) begin
						tag = PK_QHI;
					end else if (b >= UC0 && b < UD0) begin
						cur_base = win_base[3'(b - UC0)];
						uni_mode = 1'b0;
					end else if (b >= UD0 && b < UQU) begin
						tag_win = 3'(b - UD0);
						tag = PK_DEF;
					end else if (b == UDX) begin
						tag = PK_XHI;
					end else begin
						ok = 1'b0;
					end
				end else if (b == 8'h00 || b == 8'h09 || b == 8'h0A || b == 8'h0D ||
						(b >= 8'h20 && b <= 8'h7F)) begin
					push_unit({8'h00, b});
				end else if (b >= 8'h80) begin
					push_point(int'(cur_base) + b - 32'h80);
				end else if (b == SQU) begin
					tag = PK_QHI;
				end else if (b == SCU) begin
					uni_mode = 1'b1;
				end else if (b >= SQ0 && b < SQ0 + 8'd8) begin
					tag_win = 3'(b - SQ0);
					tag = PK_SQ;
				end else if (b >= SC0 && b < SD0) begin
					cur_base = win_base[3'(b - SC0)];
				end else if (b >= SD0 && b < SD0 + 8'd8) begin
					tag_win = 3'(b - SD0);
					tag = PK_DEF;
				end else if (b == SDX) begin
					tag = PK_XHI;
				end else begin
					ok = 1'b0;
				end
			end
		endcase
	endtask

	task automatic take_byte(input logic [7:0] b, input logic fb, input logic lb,
			input logic [15:0] lim);
		bit ok;
		run_len = 0;
		if (fb) begin
			open_string(lim);
			closed = 1'b0;
			// a zero limit ends the string without taking the byte
			if (unit_cap() == 20'd0) begin
				queue_word(16'h0, ST_LIMIT, 18'd0);
				closed = 1'b1;
			end
		end else if (closed) begin
			return;
		end
		if (run_len == 0) begin
			if (bytes_in < COUNT_MAX)
				bytes_in++;
			expand(b, ok);
			if (!ok) begin
				queue_word(16'h0, ST_RESERVED, bytes_in);
				closed = 1'b1;
			end else if (tag == PK_NONE && 20'(units_out) >= unit_cap()) begin
				queue_word(16'h0, ST_LIMIT, bytes_in);
				closed = 1'b1;
			end else if (lb) begin
				queue_word(16'h0, ST_ENDED, bytes_in);
				closed = 1'b1;
			end
		end
		if (run_len > 0)
			words_due[words_due.size() - 1].tail = 1'b1;
	endtask

	task automatic check_word();
		word_t w;
		if (words_due.size() == 0) begin
			report("word with none due, code_unit", 32'(code_unit), 32'h0);
			return;
		end
		w = words_due.pop_front();
		if (code_unit !== w.cu)
			report("code_unit", 32'(code_unit), 32'(w.cu));
		if (status !== w.st)
			report("status", 32'(status), 32'(w.st));
		if (byte_count !== w.cnt)
			report("byte_count", 32'(byte_count), 32'(w.cnt));
		if (last_of_run !== w.tail)
			report("last_of_run", 32'(last_of_run), 32'(w.tail));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_string(16'h0);
			closed = 1'b1;
			words_due.delete();
			run_len = 0;
			due_cnt <= 0;
		end else begin
			// a word leaves only after its byte has passed the run queue and the output register, so compare first
			if (out_valid && !out_stall)
				check_word();
			if (in_valid && !in_stall)
				take_byte(data_byte, first_byte, last_byte, unit_limit);
			due_cnt <= words_due.size();
		end
	end

endmodule

// File: bench/scsu_unicode_expander_top_tb.sv
// testbench top for the scsu expander: clock, reset, byte stimulus, output stall and verdict
`timescale 1ns / 1ps

module scsu_unicode_expander_top_tb import scsu_tag_pkg::*;;

	localparam int RUN_LIMIT = 200000;
	localparam int RAND_BYTES = 250;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        first_byte = 1'b0;
	logic        last_byte = 1'b0;
	logic [15:0] unit_limit = 16'h0000;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] code_unit;
	logic [1:0]  status;
	logic [17:0] byte_count;
	logic        last_of_run;

	int fail_count;
	int words_pending;

	int         tx_mode = 1;
	int         rx_mode = 1;
	int         rx_hold = 0;
	bit         rx_took = 1'b0;
	int         sent_bytes = 0;
	bit         gen_uni = 1'b0;
	logic [7:0] str_q [$];

	scsu_unicode_expander_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.first_byte  (first_byte),
		.last_byte   (last_byte),
		.unit_limit  (unit_limit),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_unit   (code_unit),
		.status      (status),
		.byte_count  (byte_count),
		.last_of_run (last_of_run)
	);

	scsu_expander_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.first_byte    (first_byte),
		.last_byte     (last_byte),
		.unit_limit    (unit_limit),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code_unit     (code_unit),
		.status        (status),
		.byte_count    (byte_count),
		.last_of_run   (last_of_run),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	always #5 clk = ~clk;

	// mode 0 never waits, mode 1 waits freely, mode 2 waits now and then
	function automatic int draw_wait(input int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 19);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit fb, input bit lb,
			input logic [15:0] lim);
		int gap;
		gap = draw_wait(tx_mode);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
			data_byte <= 8'($urandom);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		first_byte <= fb;
		last_byte <= lb;
		unit_limit <= lim;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic add_byte(input logic [7:0] v);
		str_q.insert(str_q.size(), v);
	endtask

	// appends one well-formed token for the current mode
	task automatic add_token();
		int unsigned r;
		logic [7:0]  v;
		r = $urandom_range(0, 99);
		if (!gen_uni) begin
			if (r < 4) begin
				case ($urandom_range(0, 3))
					0: v = 8'h00;
					1: v = 8'h09;
					2: v = 8'h0A;
					default: v = 8'h0D;
				endcase
				add_byte(v);
			end else if (r < 30) begin
				add_byte(8'($urandom_range(8'h20, 8'h7F)));
			end else if (r < 50) begin
				add_byte(8'($urandom_range(8'h80, 8'hFF)));
			end else if (r < 57) begin
				add_byte(SQ0 + 8'($urandom_range(0, 7)));
				add_byte(8'($urandom));
			end else if (r < 63) begin
				add_byte(SC0 + 8'($urandom_range(0, 7)));
			end else if (r < 70) begin
				add_byte(SD0 + 8'($urandom_range(0, 7)));
				add_byte(8'($urandom));
			end else if (r < 75) begin
				add_byte(SDX);
				add_byte(8'($urandom));
				add_byte(8'($urandom));
			end else if (r < 80) begin
				add_byte(SQU);
				add_byte(8'($urandom));
				add_byte(8'($urandom));
			end else if (r < 88) begin
				add_byte(SCU);
				gen_uni = 1'b1;
			end else begin
				add_byte(8'($urandom_range(8'h20, 8'h7F)));
			end
		end else begin
			if (r < 62 && r >= 55) begin
				add_byte(UQU);
				add_byte(8'($urandom));
				add_byte(8'($urandom));
			end else if (r >= 62 && r < 72) begin
				add_byte(UC0 + 8'($urandom_range(0, 7)));
				gen_uni = 1'b0;
			end else if (r >= 72 && r < 80) begin
				add_byte(UD0 + 8'($urandom_range(0, 7)));
				add_byte(8'($urandom));
				gen_uni = 1'b0;
			end else if (r >= 80 && r < 86) begin
				add_byte(UDX);
				add_byte(8'($urandom));
				add_byte(8'($urandom));
				gen_uni = 1'b0;
			end else begin
				// lead byte of a unit, outside the tag range
				if ($urandom_range(0, 1) == 0)
					add_byte(8'($urandom_range(8'h00, 8'hDF)));
				else
					add_byte(8'($urandom_range(8'hF3, 8'hFF)));
				add_byte(8'($urandom));
			end
		end
	endtask

	task automatic random_string();
		int unsigned r;
		logic [15:0] lim;
		bit          open_end;
		int          n;
		tx_mode = $urandom_range(0, 2);
		r = $urandom_range(0, 99);
		if (r < 10)
			lim = 16'($urandom_range(0, 3));
		else if (r < 20)
			lim = 16'($urandom);
		else if (r < 24)
			lim = 16'hFFFF;
		else
			lim = 16'($urandom_range(8, 200));
		str_q.delete();
		gen_uni = 1'b0;
		repeat ($urandom_range(1, 8))
			add_token();
		// broken endings: reserved tag, cut tag, stray byte, no last flag
		r = $urandom_range(0, 99);
		if (r < 5)
			add_byte(gen_uni ? URSV : SRSV);
		else if (r < 11 && str_q.size() > 1)
			void'(str_q.pop_back());
		else if (r < 15)
			add_byte(8'($urandom));
		open_end = ($urandom_range(0, 9) == 0);
		n = str_q.size();
		for (int i = 0; i < n; i++)
			send_byte(str_q[i], i == 0, (i == n - 1) && !open_end,
				(i == 0) ? lim : 16'($urandom));
		sent_bytes += n;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 16'($urandom));
	endtask

	task automatic directed_bytes();
		// zero limit
		send_byte(8'h41, 1'b1, 1'b0, 16'h0000);
		// reserved tag in unicode mode, then a byte after the end
		send_byte(SCU, 1'b1, 1'b0, 16'hFFFF);
		send_byte(URSV, 1'b0, 1'b0, 16'hFFFF);
		send_byte(8'h55, 1'b0, 1'b0, 16'h0000);
		// top extended window, two surrogate pairs overshoot a limit of three
		send_byte(SDX, 1'b1, 1'b0, 16'd3);
		send_byte(8'hFF, 1'b0, 1'b0, 16'h0000);
		send_byte(8'hFF, 1'b0, 1'b0, 16'h0000);
		send_byte(8'hFF, 1'b0, 1'b0, 16'h0000);
		send_byte(8'h80, 1'b0, 1'b0, 16'h0000);
		// reserved tag in single-byte mode
		send_byte(SRSV, 1'b1, 1'b0, 16'd100);
		// reserved offset, window change, quoted unit, fixed offset, static quote
		send_byte(SD0, 1'b1, 1'b0, 16'd100);
		send_byte(8'hA8, 1'b0, 1'b0, 16'h0000);
		send_byte(8'h85, 1'b0, 1'b0, 16'h0000);
		send_byte(SC0 + 8'd1, 1'b0, 1'b0, 16'h0000);
		send_byte(8'h80, 1'b0, 1'b0, 16'h0000);
		send_byte(SCU, 1'b0, 1'b0, 16'h0000);
		send_byte(UQU, 1'b0, 1'b0, 16'h0000);
		send_byte(URSV, 1'b0, 1'b0, 16'h0000);
		send_byte(8'h00, 1'b0, 1'b0, 16'h0000);
		send_byte(UD0 + 8'd1, 1'b0, 1'b0, 16'h0000);
		send_byte(8'hF9, 1'b0, 1'b0, 16'h0000);
		send_byte(SCU, 1'b0, 1'b0, 16'h0000);
		send_byte(UC0 + 8'd2, 1'b0, 1'b0, 16'h0000);
		send_byte(SQ0, 1'b0, 1'b0, 16'h0000);
		send_byte(8'h41, 1'b0, 1'b0, 16'h0000);
		// source ends with a quote tag half read
		send_byte(SQU, 1'b0, 1'b1, 16'h0000);
	endtask

	always @(posedge clk)
		rx_took <= out_valid && !out_stall;

	// after each word taken, hold off for a drawn number of cycles
	always @(negedge clk) begin
		if (rx_took) begin
			if ($urandom_range(0, 39) == 0)
				rx_mode = $urandom_range(0, 2);
			rx_hold = draw_wait(rx_mode);
		end
		if (rx_hold > 0) begin
			out_stall <= 1'b1;
			rx_hold--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		int cyc;
		cyc = 0;
		while (cyc < RUN_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		directed_bytes();
		while (sent_bytes < RAND_BYTES)
			random_string();
		@(negedge clk);
		in_valid <= 1'b0;
		while (words_pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && words_pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
